// ===== src/dlr_pkg.sv =====
`default_nettype none
package dlr_pkg;
	localparam int Span = 31;
	localparam int FrameCols = 2 * Span;
	localparam int FrameRows = Span;
	localparam int FrameCells = FrameCols * FrameRows;
	localparam int AddrW = $clog2(FrameCells);
	localparam int DepthLevels = 7;
	localparam int DepthDen = 2 * Span + 1;

	typedef enum logic [1:0] {
		REQ_DRAW  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_READ, ST_READ_WAIT, ST_SETUP, ST_DIV,
		ST_PLOT_RD, ST_PLOT_WR, ST_NEXT, ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic init_clear;
		logic clear_step;
		logic read_issue;
		logic read_capture;
		logic pass_setup;
		logic div_start;
		logic plot_read;
		logic plot_write;
		logic advance;
		logic out_load;
	} dlr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic pass_empty;
		logic div_done;
		logic pass_done;
		logic last_pass;
		logic first_done;
	} dlr_sts_t;
endpackage
`default_nettype wire

// ===== src/depth_line_rasterizer.sv =====
// Depth-keeping line rasterizer over a 62 x 31 cell frame store. A draw walks
// rows then columns of the segment; each visited cell costs two 17-step
// divisions in one shared serial divider plus a read-modify-write of the frame
// memory. A clear sweeps the 1922-entry memory one cell a cycle, and after
// reset the same clearing pass runs before the first item.
`default_nettype none
module depth_line_rasterizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// req_type[1:0]
	input  wire logic [1:0]  s_tuser,
	// start_x, start_y, start_z, end_x, end_y, end_z, read_col, read_row
	input  wire logic [63:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// cell_value[2:0], cells_plotted[11:3]
	output logic [15:0]      m_tdata
);
	dlr_pkg::dlr_cmd_t cmd;
	dlr_pkg::dlr_sts_t sts;
	logic [2:0] cell_value;
	logic [8:0] cells_plotted;

	dlr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.req_type(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.sts(sts), .cmd(cmd)
	);

	dlr_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .req_type(s_tuser),
		.start_x(s_tdata[7:0]), .start_y(s_tdata[15:8]), .start_z(s_tdata[23:16]),
		.end_x(s_tdata[31:24]), .end_y(s_tdata[39:32]), .end_z(s_tdata[47:40]),
		.read_col(s_tdata[53:48]), .read_row(s_tdata[58:54]),
		.cell_value(cell_value), .cells_plotted(cells_plotted)
	);

	assign m_tdata = {4'd0, cells_plotted, cell_value};

	// no input taken while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken with result pending");
	// one result follows a single out state
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid) else $error("result not presented");
endmodule
`default_nettype wire

// ===== src/dlr_div.sv =====
`default_nettype none
// restoring divider for signed 17-bit by signed 9-bit, truncating quotient
module dlr_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [16:0] num,
	input  wire logic signed [8:0]  den,
	output logic                    done,
	output logic signed [16:0]      quot
);
	logic [16:0] rem_q;
	logic [16:0] mag_q;
	logic [8:0]  dmag_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [17:0] trial;
	logic [16:0] shifted;

	always_comb begin
		shifted = {rem_q[15:0], mag_q[16]};
		trial = {1'b0, shifted} - {9'd0, dmag_q};
	end

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd17;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			mag_q <= num[16] ? 17'(-num) : 17'(num);
			dmag_q <= den[8] ? 9'(-den) : 9'(den);
			neg_q <= num[16] ^ den[8];
		end else if (busy_q) begin
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				mag_q <= {mag_q[15:0], 1'b1};
			end else begin
				rem_q <= shifted;
				mag_q <= {mag_q[15:0], 1'b0};
			end
		end
	end

	assign quot = neg_q ? 17'(-mag_q) : 17'(mag_q);
endmodule
`default_nettype wire

// ===== src/dlr_datapath.sv =====
`default_nettype none
module dlr_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dlr_pkg::dlr_cmd_t cmd,
	output dlr_pkg::dlr_sts_t     sts,
	input  wire logic [1:0]       req_type,
	input  wire logic signed [7:0] start_x,
	input  wire logic signed [7:0] start_y,
	input  wire logic signed [7:0] start_z,
	input  wire logic signed [7:0] end_x,
	input  wire logic signed [7:0] end_y,
	input  wire logic signed [7:0] end_z,
	input  wire logic [5:0]       read_col,
	input  wire logic [4:0]       read_row,
	output logic [2:0]            cell_value,
	output logic [8:0]            cells_plotted
);
	localparam int AW = dlr_pkg::AddrW;

	logic [2:0] mem [dlr_pkg::FrameCells];
	logic signed [7:0] xs_q, ys_q, zs_q, xe_q, ye_q, ze_q;
	logic [5:0] rcol_q;
	logic [4:0] rrow_q;
	logic [1:0] req_q;
	logic       pass_q;
	logic signed [8:0] a0_q, hi_q, i_q, den_q;
	logic signed [8:0] p0_q, dp_q, z0_q, dz_q;
	logic signed [16:0] pq_q;
	logic       which_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] addr_q;
	logic       inb_q;
	logic [2:0] lvl_q;
	logic [2:0] rd_q;
	logic [8:0] cnt_q;
	logic       div_start;
	logic signed [16:0] num;
	logic       div_done;
	logic signed [16:0] quot;

	// pass selection: row pass then column pass
	logic signed [8:0] pa0, pa1, pp0, pp1;
	always_comb begin
		if (!pass_q) begin
			pa0 = 9'(ys_q); pa1 = 9'(ye_q); pp0 = 9'(xs_q); pp1 = 9'(xe_q);
		end else begin
			pa0 = 9'(xs_q); pa1 = 9'(xe_q); pp0 = 9'(ys_q); pp1 = 9'(ye_q);
		end
	end

	// divider shared by the carried coordinate and depth
	assign num = (which_q ? dz_q : dp_q) * 17'(i_q - a0_q);
	assign div_start = cmd.div_start;
	dlr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(num),
		.den(den_q), .done(div_done), .quot(quot)
	);

	// cell position and level from the quotients
	logic signed [17:0] pv, zv;
	logic signed [17:0] col, row;
	logic signed [17:0] prod7;
	logic [2:0] lvl;
	always_comb begin
		pv = 18'(p0_q) + 18'(pq_q);
		zv = 18'(z0_q) + 18'(quot);
		col = pass_q ? 18'(i_q) : pv;
		row = pass_q ? pv : 18'(i_q);
		prod7 = zv * 18'sd7;
		// level is the number of depth thresholds reached, top level clamps
		lvl = 3'd0;
		if (zv >= 0) begin
			for (int k = 1; k < dlr_pkg::DepthLevels; k++)
				if (prod7 >= 18'(k * dlr_pkg::DepthDen)) lvl = 3'(k);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xs_q <= start_x; ys_q <= start_y; zs_q <= start_z;
			xe_q <= end_x; ye_q <= end_y; ze_q <= end_z;
			rcol_q <= read_col; rrow_q <= read_row; req_q <= req_type;
		end
		if (cmd.pass_setup) begin
			a0_q <= pa0;
			den_q <= pa1 - pa0;
			i_q <= (pa0 < pa1) ? pa0 : pa1;
			hi_q <= (pa0 < pa1) ? pa1 : pa0;
			p0_q <= pp0;
			dp_q <= pp1 - pp0;
			z0_q <= 9'(zs_q);
			dz_q <= 9'(ze_q) - 9'(zs_q);
			which_q <= 1'b0;
		end
		if (div_done && !which_q) begin
			pq_q <= quot;
			which_q <= 1'b1;
		end
		if (div_done && which_q) begin
			inb_q <= col >= 0 && row >= 0 && col < 18'(dlr_pkg::FrameCols)
				&& row < 18'(dlr_pkg::FrameRows);
			addr_q <= AW'(row * 18'(dlr_pkg::FrameCols) + col);
			lvl_q <= lvl;
		end
		if (cmd.advance) begin
			i_q <= i_q + 9'sd1;
			which_q <= 1'b0;
		end
		if (cmd.read_issue)
			addr_q <= AW'(rrow_q) * AW'(dlr_pkg::FrameCols) + AW'(rcol_q);
		if (cmd.plot_read || cmd.read_capture) rd_q <= mem[addr_q];
		if (cmd.plot_write && inb_q && (rd_q == 3'd0 || rd_q - 3'd1 < lvl_q))
			mem[addr_q] <= lvl_q + 3'd1;
		if (cmd.clear_step) mem[clr_q] <= 3'd0;
		if (cmd.out_load) begin
			cell_value <= (req_q == dlr_pkg::REQ_READ && rcol_q < 6'(dlr_pkg::FrameCols)
				&& rrow_q < 5'(dlr_pkg::FrameRows)) ? rd_q : 3'd0;
			cells_plotted <= (req_q == dlr_pkg::REQ_DRAW) ? cnt_q : 9'd0;
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0; pass_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (cmd.init_clear) clr_q <= '0;
			else if (cmd.clear_step) clr_q <= clr_q + AW'(1);
			if (cmd.load) begin
				pass_q <= 1'b0;
				if (req_type == dlr_pkg::REQ_DRAW) cnt_q <= '0;
			end
			if (cmd.advance && i_q + 9'sd1 >= hi_q) pass_q <= 1'b1;
			if (cmd.pass_setup && pa0 == pa1) pass_q <= 1'b1;
			if (cmd.plot_write && inb_q) cnt_q <= cnt_q + 9'd1;
		end
	end

	assign sts.clear_done = clr_q == AW'(dlr_pkg::FrameCells - 1);
	assign sts.pass_empty = pa0 == pa1;
	assign sts.div_done = div_done && which_q;
	assign sts.pass_done = i_q + 9'sd1 >= hi_q;
	assign sts.last_pass = pass_q;
	assign sts.first_done = div_done && !which_q;
endmodule
`default_nettype wire

// ===== src/dlr_ctrl.sv =====
`default_nettype none
module dlr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [1:0]        req_type,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	input  wire dlr_pkg::dlr_sts_t sts,
	output dlr_pkg::dlr_cmd_t      cmd
);
	dlr_pkg::state_t state_q, state_d;
	logic rst_clear_q;
	logic first_q;
	logic half_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dlr_pkg::ST_IDLE:
				if (rst_clear_q) state_d = dlr_pkg::ST_CLEAR;
				else if (s_tvalid && !m_tvalid) begin
					case (req_type)
						dlr_pkg::REQ_DRAW:  state_d = dlr_pkg::ST_SETUP;
						dlr_pkg::REQ_READ:  state_d = dlr_pkg::ST_READ;
						dlr_pkg::REQ_CLEAR: state_d = dlr_pkg::ST_CLEAR;
						default:            state_d = dlr_pkg::ST_OUT;
					endcase
				end
			dlr_pkg::ST_CLEAR:
				if (sts.clear_done) state_d = rst_clear_q ? dlr_pkg::ST_IDLE : dlr_pkg::ST_OUT;
			dlr_pkg::ST_READ: state_d = dlr_pkg::ST_READ_WAIT;
			dlr_pkg::ST_READ_WAIT: state_d = dlr_pkg::ST_OUT;
			dlr_pkg::ST_SETUP:
				if (sts.pass_empty) state_d = sts.last_pass ? dlr_pkg::ST_OUT : dlr_pkg::ST_SETUP;
				else state_d = dlr_pkg::ST_DIV;
			dlr_pkg::ST_DIV: if (sts.div_done) state_d = dlr_pkg::ST_PLOT_RD;
			dlr_pkg::ST_PLOT_RD: state_d = dlr_pkg::ST_PLOT_WR;
			dlr_pkg::ST_PLOT_WR: state_d = dlr_pkg::ST_NEXT;
			dlr_pkg::ST_NEXT:
				if (!sts.pass_done) state_d = dlr_pkg::ST_DIV;
				else state_d = sts.last_pass ? dlr_pkg::ST_OUT : dlr_pkg::ST_SETUP;
			dlr_pkg::ST_OUT: state_d = dlr_pkg::ST_IDLE;
			default: state_d = dlr_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		s_tready = state_q == dlr_pkg::ST_IDLE && !rst_clear_q && !m_tvalid;
		case (state_q)
			dlr_pkg::ST_IDLE: begin
				cmd.load = s_tready && s_tvalid;
				cmd.init_clear = 1'b1;
			end
			dlr_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
			dlr_pkg::ST_READ: cmd.read_issue = 1'b1;
			dlr_pkg::ST_READ_WAIT: cmd.read_capture = 1'b1;
			dlr_pkg::ST_SETUP: cmd.pass_setup = 1'b1;
			dlr_pkg::ST_DIV: cmd.div_start = first_q || half_q;
			dlr_pkg::ST_PLOT_RD: cmd.plot_read = 1'b1;
			dlr_pkg::ST_PLOT_WR: cmd.plot_write = 1'b1;
			dlr_pkg::ST_NEXT: cmd.advance = 1'b1;
			dlr_pkg::ST_OUT: cmd.out_load = 1'b1;
			default: cmd = '0;
		endcase
	end

	// state, reset clear flag, result valid and divider sequencing: start on entry and after the first quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlr_pkg::ST_IDLE;
			rst_clear_q <= 1'b1;
			first_q <= 1'b0;
			half_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dlr_pkg::ST_CLEAR && sts.clear_done) rst_clear_q <= 1'b0;
			first_q <= state_d == dlr_pkg::ST_DIV && state_q != dlr_pkg::ST_DIV;
			half_q <= state_q == dlr_pkg::ST_DIV && sts.first_done;
			if (state_q == dlr_pkg::ST_OUT) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// one request word as the block sees it
	typedef struct {
		dlr_pkg::req_t    kind;
		logic signed [7:0] xs, ys, zs, xe, ye, ze;
		logic [5:0]       col;
		logic [4:0]       row;
	} draw_req_t;

	// one expected result word
	typedef struct {
		logic [2:0] pix;
		logic [8:0] plotted;
	} frame_result_t;

	// frame shadow, depth math and pending results
	class frame_scoreboard;
		logic [2:0]    shadow [dlr_pkg::FrameCells];
		int            plot_count;
		frame_result_t pending [$];
		int            errors;

		function new();
			foreach (shadow[i]) shadow[i] = '0;
			errors = 0;
		endfunction

		function void plot(int c, int r, int z);
			int lvl;
			int idx;
			if (c < 0 || r < 0 || c >= dlr_pkg::FrameCols || r >= dlr_pkg::FrameRows) return;
			lvl = (z < 0) ? 0 : (z * dlr_pkg::DepthLevels) / dlr_pkg::DepthDen;
			if (lvl > dlr_pkg::DepthLevels - 1) lvl = dlr_pkg::DepthLevels - 1;
			idx = r * dlr_pkg::FrameCols + c;
			if (shadow[idx] == 0 || int'(shadow[idx]) - 1 < lvl)
				shadow[idx] = 3'(lvl + 1);
			plot_count++;
		endfunction

		// walk one axis, interpolating the other coordinate and depth
		function void walk(int a0, int a1, int p0, int p1, int z0, int z1, bit by_row);
			int lo, hi, den, p, z;
			lo = a0 < a1 ? a0 : a1;
			hi = a0 < a1 ? a1 : a0;
			den = a1 - a0;
			if (den == 0) return;
			for (int i = lo; i < hi; i++) begin
				p = p0 + (p1 - p0) * (i - a0) / den;
				z = z0 + (z1 - z0) * (i - a0) / den;
				if (by_row) plot(p, i, z);
				else plot(i, p, z);
			end
		endfunction

		function void note_request(draw_req_t q);
			frame_result_t res;
			res.pix = '0;
			res.plotted = '0;
			case (q.kind)
				dlr_pkg::REQ_DRAW: begin
					plot_count = 0;
					walk(q.ys, q.ye, q.xs, q.xe, q.zs, q.ze, 1'b1);
					walk(q.xs, q.xe, q.ys, q.ye, q.zs, q.ze, 1'b0);
					res.plotted = 9'(plot_count);
				end
				dlr_pkg::REQ_READ: begin
					if (q.col < dlr_pkg::FrameCols && q.row < dlr_pkg::FrameRows)
						res.pix = shadow[q.row * dlr_pkg::FrameCols + q.col];
				end
				dlr_pkg::REQ_CLEAR: foreach (shadow[i]) shadow[i] = '0;
				default: ;
			endcase
			pending = {pending, res};
		endfunction

		function void check_result(logic [15:0] w);
			frame_result_t exp_res;
			if (pending.size() == 0) begin
				$display("%t: unexpected word %h", $realtime, w);
				errors++;
				return;
			end
			exp_res = pending.pop_front();
			if (w[2:0] !== exp_res.pix) begin
				$display("%t: cell_value expected %0d actual %0d", $realtime,
					exp_res.pix, w[2:0]);
				errors++;
			end
			if (w[11:3] !== exp_res.plotted) begin
				$display("%t: cells_plotted expected %0d actual %0d", $realtime,
					exp_res.plotted, w[11:3]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	frame_scoreboard board = new();
	bit calm = 1'b0;

	depth_line_rasterizer i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	// send one request word, then maybe idle for a burst
	task automatic send_req(draw_req_t q);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = q.kind;
		s_tdata = {5'b0, q.row, q.col, q.ze, q.ye, q.xe, q.zs, q.ys, q.xs};
		do @(posedge clk); while (!s_tready);
		board.note_request(q);
		if (!calm && $urandom_range(3) == 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat ($urandom_range(11)) @(negedge clk);
		end
	endtask

	function automatic draw_req_t make_req(dlr_pkg::req_t k, int xs, int ys, int zs,
			int xe, int ye, int ze, int c, int r);
		draw_req_t q;
		q.kind = k;
		q.xs = 8'(xs); q.ys = 8'(ys); q.zs = 8'(zs);
		q.xe = 8'(xe); q.ye = 8'(ye); q.ze = 8'(ze);
		q.col = 6'(c); q.row = 5'(r);
		return q;
	endfunction

	function automatic int near(int base, int span);
		return base + $urandom_range(2 * span) - span;
	endfunction

	// random word: draws (mostly short segments around the frame), reads, clears or none
	function automatic draw_req_t random_req();
		draw_req_t q;
		int pick, x0, y0;
		q = make_req(dlr_pkg::REQ_DRAW, $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(63), $urandom_range(31));
		pick = $urandom_range(99);
		if (pick < 52) begin
			if ($urandom_range(30) != 0) begin
				x0 = near(31, 36);
				y0 = near(15, 19);
				q.xs = 8'(x0); q.ys = 8'(y0);
				q.xe = 8'(near(x0, 9)); q.ye = 8'(near(y0, 7));
			end
		end else if (pick < 94) q.kind = dlr_pkg::REQ_READ;
		else if (pick < 98) q.kind = dlr_pkg::REQ_CLEAR;
		else q.kind = dlr_pkg::REQ_NONE;
		return q;
	endfunction

	// result side stall bursts
	initial begin
		forever begin
			@(negedge clk);
			if (calm || $urandom_range(2) != 0) begin
				m_tready = 1'b1;
				repeat ($urandom_range(12)) @(negedge clk);
			end else begin
				m_tready = 1'b0;
				repeat ($urandom_range(11)) @(negedge clk);
			end
		end
	end

	always @(posedge clk)
		if (m_tvalid && m_tready) board.check_result(m_tdata);

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words
		send_req(make_req(dlr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_req(dlr_pkg::REQ_DRAW, 0, 0, 127, 61, 30, 127, 0, 0));
		send_req(make_req(dlr_pkg::REQ_DRAW, 61, 0, -128, 0, 30, -128, 0, 0));
		send_req(make_req(dlr_pkg::REQ_DRAW, 5, 3, 10, 5, 20, 60, 0, 0));   // same column
		send_req(make_req(dlr_pkg::REQ_DRAW, 2, 9, 40, 50, 9, 0, 0, 0));    // same row
		send_req(make_req(dlr_pkg::REQ_DRAW, 7, 7, 0, 7, 7, 0, 0, 0));      // single point
		send_req(make_req(dlr_pkg::REQ_DRAW, -128, -128, -128, 127, 127, 127, 0, 0));
		send_req(make_req(dlr_pkg::REQ_DRAW, 127, -128, 127, -128, 127, -128, 0, 0));
		send_req(make_req(dlr_pkg::REQ_DRAW, -20, -5, 200, 90, 45, 100, 0, 0));
		send_req(make_req(dlr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_req(dlr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 61, 30));
		send_req(make_req(dlr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 5, 10));
		send_req(make_req(dlr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 30, 9));
		send_req(make_req(dlr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 62, 4));     // off frame column
		send_req(make_req(dlr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 63, 31));
		send_req(make_req(dlr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 10, 31));    // off frame row
		send_req(make_req(dlr_pkg::REQ_NONE, 85, -86, 3, -1, 127, 33, 42, 21));
		send_req(make_req(dlr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 20, 10));
		send_req(make_req(dlr_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_req(dlr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 20, 10));
		send_req(make_req(dlr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));

		for (int n = 0; n < 1130; n++) begin
			if (n == 1000) calm = 1'b1;
			send_req(random_req());
		end
		@(negedge clk);
		s_tvalid = 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#80ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
